@@ design/bblur_pkg.sv @@
`timescale 1ns / 1ps
// shared types and constants for the 3x3 border-aware box blur
// no dependencies
package bblur_pkg;

    localparam int CH_W        = 8;
    localparam int PIX_W       = 3 * CH_W;
    localparam int SUM_W       = 12;
    localparam int RECIP_W     = 15;
    localparam int RECIP_SHIFT = 16;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 11;
    localparam int QUEUE_DEPTH = 4;

    localparam logic [CFG_DATA_W-1:0] FRAME_WIDTH_RST  = 11'd640;
    localparam logic [CFG_DATA_W-1:0] FRAME_HEIGHT_RST = 11'd480;

    // mean = (s + bias) * recip >> 16, exact for every reachable sum
    localparam logic [SUM_W-1:0]   BIAS_CORNER  = 12'd2;
    localparam logic [SUM_W-1:0]   BIAS_EDGE    = 12'd3;
    localparam logic [SUM_W-1:0]   BIAS_INNER   = 12'd4;
    localparam logic [RECIP_W-1:0] RECIP_CORNER = 15'd16384;
    localparam logic [RECIP_W-1:0] RECIP_EDGE   = 15'd10923;
    localparam logic [RECIP_W-1:0] RECIP_INNER  = 15'd7282;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FRAME_WIDTH  = 2'd0,
        CFG_FRAME_HEIGHT = 2'd1
    } cfg_reg_t;

    typedef enum logic {
        OP_PUSH  = 1'b0,
        OP_DRAIN = 1'b1
    } op_t;

    typedef enum logic [1:0] {
        AREA_CORNER,
        AREA_EDGE,
        AREA_INNER
    } area_t;

    typedef struct packed {
        logic emit;
        logic row_above;
        logic row_below;
        logic col_left;
        logic col_right;
        logic last;
    } ctl_t;

endpackage

@@ design/bblur_ram.sv @@
`timescale 1ns / 1ps
// generic simple dual-port ram, one write port and one registered read port
// no dependencies
module bblur_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ design/bblur_front.sv @@
`timescale 1ns / 1ps
// front end: size registers, frame position counters and item classification
// depends on bblur_pkg
module bblur_front #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024,
    localparam int COL_W  = $clog2(MAX_WIDTH),
    localparam int ROW_W  = $clog2(MAX_HEIGHT + 2),
    localparam int OROW_W = $clog2(MAX_HEIGHT),
    localparam int WID_W  = $clog2(MAX_WIDTH + 1),
    localparam int HGT_W  = $clog2(MAX_HEIGHT + 1)
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_wr,
    input  logic [bblur_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [bblur_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                              in_acc,
    input  logic                              opcode,
    input  logic [bblur_pkg::CH_W-1:0]        red_in,
    input  logic [bblur_pkg::CH_W-1:0]        green_in,
    input  logic [bblur_pkg::CH_W-1:0]        blue_in,
    output logic                              q_push,
    output logic [bblur_pkg::PIX_W-1:0]       q_pix,
    output logic [COL_W-1:0]                  q_col,
    output bblur_pkg::ctl_t                   q_ctl
);

    logic [bblur_pkg::CFG_DATA_W-1:0] frame_width_reg, frame_width_next;
    logic [bblur_pkg::CFG_DATA_W-1:0] frame_height_reg, frame_height_next;
    logic [ROW_W-1:0]  in_row_reg, in_row_next;
    logic [COL_W-1:0]  in_col_reg, in_col_next;
    logic [OROW_W-1:0] out_row_reg, out_row_next;
    logic [COL_W-1:0]  out_col_reg, out_col_next;

    logic [WID_W-1:0] eff_w;
    logic [HGT_W-1:0] eff_h;
    logic             pixel_slot;
    logic             is_push;
    logic             in_col_wrap;
    logic             out_col_wrap;
    logic             cfg_hit;
    bblur_pkg::ctl_t  ctl;

    // sizes clamped to the supported range
    always_comb
    begin
        priority if (frame_width_reg < 11'd2)
            eff_w = WID_W'(2);
        else if (32'(frame_width_reg) > MAX_WIDTH)
            eff_w = WID_W'(MAX_WIDTH);
        else
            eff_w = WID_W'(frame_width_reg);

        priority if (frame_height_reg < 11'd2)
            eff_h = HGT_W'(2);
        else if (32'(frame_height_reg) > MAX_HEIGHT)
            eff_h = HGT_W'(MAX_HEIGHT);
        else
            eff_h = HGT_W'(frame_height_reg);
    end

    assign is_push      = (opcode == bblur_pkg::OP_PUSH);
    assign pixel_slot   = 32'(in_row_reg) < 32'(eff_h);
    assign in_col_wrap  = (32'(in_col_reg) + 32'd1) >= 32'(eff_w);
    assign out_col_wrap = (32'(out_col_reg) + 32'd1) >= 32'(eff_w);
    assign cfg_hit      = cfg_wr && ((cfg_index == bblur_pkg::CFG_FRAME_WIDTH) ||
                                     (cfg_index == bblur_pkg::CFG_FRAME_HEIGHT));

    always_comb
    begin
        ctl.emit      = (in_row_reg > ROW_W'(1)) ||
                        ((in_row_reg == ROW_W'(1)) && (in_col_reg != '0));
        ctl.row_above = (out_row_reg != '0);
        ctl.row_below = (32'(out_row_reg) + 32'd1) < 32'(eff_h);
        ctl.col_left  = (out_col_reg != '0);
        ctl.col_right = !out_col_wrap;
        ctl.last      = !ctl.row_below && out_col_wrap;
    end

    // drain ticks that arrive while pixels are still due are dropped
    assign q_push = in_acc && (is_push || !pixel_slot);
    assign q_pix  = pixel_slot ? {red_in, green_in, blue_in} : '0;
    assign q_col  = in_col_reg;
    assign q_ctl  = ctl;

    always_comb
    begin
        frame_width_next  = frame_width_reg;
        frame_height_next = frame_height_reg;
        in_row_next       = in_row_reg;
        in_col_next       = in_col_reg;
        out_row_next      = out_row_reg;
        out_col_next      = out_col_reg;
        if (cfg_wr && (cfg_index == bblur_pkg::CFG_FRAME_WIDTH))
        begin
            frame_width_next = cfg_data;
        end
        if (cfg_wr && (cfg_index == bblur_pkg::CFG_FRAME_HEIGHT))
        begin
            frame_height_next = cfg_data;
        end
        priority if (cfg_hit)
        begin
            in_row_next  = '0;
            in_col_next  = '0;
            out_row_next = '0;
            out_col_next = '0;
        end
        else if (q_push)
        begin
            if (in_col_wrap)
            begin
                in_col_next = '0;
                in_row_next = in_row_reg + ROW_W'(1);
            end
            else
            begin
                in_col_next = in_col_reg + COL_W'(1);
            end
            if (ctl.emit)
            begin
                priority if (ctl.last)
                begin
                    in_row_next  = '0;
                    in_col_next  = '0;
                    out_row_next = '0;
                    out_col_next = '0;
                end
                else if (out_col_wrap)
                begin
                    out_col_next = '0;
                    out_row_next = out_row_reg + OROW_W'(1);
                end
                else
                begin
                    out_col_next = out_col_reg + COL_W'(1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg  <= bblur_pkg::FRAME_WIDTH_RST;
            frame_height_reg <= bblur_pkg::FRAME_HEIGHT_RST;
            in_row_reg       <= '0;
            in_col_reg       <= '0;
            out_row_reg      <= '0;
            out_col_reg      <= '0;
        end
        else
        begin
            frame_width_reg  <= frame_width_next;
            frame_height_reg <= frame_height_next;
            in_row_reg       <= in_row_next;
            in_col_reg       <= in_col_next;
            out_row_reg      <= out_row_next;
            out_col_reg      <= out_col_next;
        end
    end

endmodule

@@ design/bblur_queue.sv @@
`timescale 1ns / 1ps
// small register fifo between the front end and the blur pipeline
// no dependencies
module bblur_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4,
    localparam int PTR_W = $clog2(DEPTH),
    localparam int CNT_W = $clog2(DEPTH + 1)
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    input  logic             pop,
    output logic             full,
    output logic             not_empty,
    output logic [WIDTH-1:0] head
);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full      = (count_reg == CNT_W'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign head      = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + PTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + PTR_W'(1) : rd_ptr_reg;
        unique case ({push, pop})
            2'b10:   count_next = count_reg + CNT_W'(1);
            2'b01:   count_next = count_reg - CNT_W'(1);
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

@@ design/bblur_back.sv @@
`timescale 1ns / 1ps
// blur pipeline: line buffer access, 3x3 window, masked sums, mean and output register
// depends on bblur_pkg and bblur_ram
module bblur_back #(
    parameter int MAX_WIDTH = 1024,
    localparam int COL_W = $clog2(MAX_WIDTH)
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        q_valid,
    input  logic [bblur_pkg::PIX_W-1:0] q_pix,
    input  logic [COL_W-1:0]            q_col,
    input  bblur_pkg::ctl_t             q_ctl,
    output logic                        q_pop,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [bblur_pkg::CH_W-1:0]  red_out,
    output logic [bblur_pkg::CH_W-1:0]  green_out,
    output logic [bblur_pkg::CH_W-1:0]  blue_out,
    output logic                        frame_end
);

    localparam int PIX_W   = bblur_pkg::PIX_W;
    localparam int CH_W    = bblur_pkg::CH_W;
    localparam int SUM_W   = bblur_pkg::SUM_W;
    localparam int RECIP_W = bblur_pkg::RECIP_W;
    localparam int PROD_W  = SUM_W + RECIP_W;

    logic en;

    logic              s1_valid_reg;
    logic [PIX_W-1:0]  s1_pix_reg;
    logic [COL_W-1:0]  s1_col_reg;
    bblur_pkg::ctl_t   s1_ctl_reg;

    logic [2*PIX_W-1:0] ram_rd;
    logic [PIX_W-1:0]   upper_rd;
    logic [PIX_W-1:0]   middle_rd;

    logic [PIX_W-1:0]  win_reg [3][3];
    logic              s2_valid_reg;
    bblur_pkg::ctl_t   s2_ctl_reg;

    logic [2:0]        row_en;
    logic [2:0]        col_en;
    logic [SUM_W-1:0]  row_sum [3][3];
    logic [SUM_W-1:0]  ch_sum [3];
    bblur_pkg::area_t  area;
    logic [SUM_W-1:0]  bias;
    logic [RECIP_W-1:0] recip;

    logic              s3_valid_reg;
    logic [SUM_W-1:0]  s3_num_reg [3];
    logic [RECIP_W-1:0] s3_recip_reg;
    logic              s3_last_reg;

    logic [PROD_W-1:0] prod [3];
    logic              out_valid_reg;
    logic [CH_W-1:0]   chan_out_reg [3];
    logic              frame_end_reg;

    // whole pipeline advances unless the output register holds an untaken result
    assign en    = !out_valid_reg || !out_stall;
    assign q_pop = en && q_valid;

    // each entry holds {upper line, middle line} for one column
    bblur_ram #(
        .WIDTH (2 * PIX_W),
        .DEPTH (MAX_WIDTH)
    ) u_line_ram (
        .clk     (clk),
        .wr_en   (en && s1_valid_reg),
        .wr_addr (s1_col_reg),
        .wr_data ({middle_rd, s1_pix_reg}),
        .rd_en   (q_pop),
        .rd_addr (q_col),
        .rd_data (ram_rd)
    );

    assign upper_rd  = ram_rd[2*PIX_W-1:PIX_W];
    assign middle_rd = ram_rd[PIX_W-1:0];

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            s1_pix_reg <= q_pix;
            s1_col_reg <= q_col;
            s1_ctl_reg <= q_ctl;
        end
        if (en && s1_valid_reg)
        begin
            for (int r = 0; r < 3; r++)
            begin
                win_reg[r][0] <= win_reg[r][1];
                win_reg[r][1] <= win_reg[r][2];
            end
            win_reg[0][2] <= upper_rd;
            win_reg[1][2] <= middle_rd;
            win_reg[2][2] <= s1_pix_reg;
            s2_ctl_reg    <= s1_ctl_reg;
        end
        if (en && s2_valid_reg)
        begin
            for (int ch = 0; ch < 3; ch++)
            begin
                s3_num_reg[ch] <= ch_sum[ch] + bias;
            end
            s3_recip_reg <= recip;
            s3_last_reg  <= s2_ctl_reg.last;
        end
        if (en && s3_valid_reg)
        begin
            for (int ch = 0; ch < 3; ch++)
            begin
                chan_out_reg[ch] <= prod[ch][bblur_pkg::RECIP_SHIFT +: CH_W];
            end
            frame_end_reg <= s3_last_reg;
        end
    end

    // masked neighbourhood sums, window row 0 is the oldest line, column 0 the oldest pixel
    assign row_en = {s2_ctl_reg.row_below, 1'b1, s2_ctl_reg.row_above};
    assign col_en = {s2_ctl_reg.col_right, 1'b1, s2_ctl_reg.col_left};

    always_comb
    begin
        for (int ch = 0; ch < 3; ch++)
        begin
            ch_sum[ch] = '0;
            for (int r = 0; r < 3; r++)
            begin
                row_sum[ch][r] = '0;
                for (int c = 0; c < 3; c++)
                begin
                    if (row_en[r] && col_en[c])
                    begin
                        row_sum[ch][r] = row_sum[ch][r] +
                                         SUM_W'(win_reg[r][c][(2 - ch) * CH_W +: CH_W]);
                    end
                end
                ch_sum[ch] = ch_sum[ch] + row_sum[ch][r];
            end
        end
    end

    always_comb
    begin
        priority if (s2_ctl_reg.row_above && s2_ctl_reg.row_below &&
                     s2_ctl_reg.col_left && s2_ctl_reg.col_right)
            area = bblur_pkg::AREA_INNER;
        else if (!(s2_ctl_reg.row_above && s2_ctl_reg.row_below) &&
                 !(s2_ctl_reg.col_left && s2_ctl_reg.col_right))
            area = bblur_pkg::AREA_CORNER;
        else
            area = bblur_pkg::AREA_EDGE;
    end

    always_comb
    begin
        unique case (area)
            bblur_pkg::AREA_CORNER:
            begin
                bias  = bblur_pkg::BIAS_CORNER;
                recip = bblur_pkg::RECIP_CORNER;
            end
            bblur_pkg::AREA_EDGE:
            begin
                bias  = bblur_pkg::BIAS_EDGE;
                recip = bblur_pkg::RECIP_EDGE;
            end
            bblur_pkg::AREA_INNER:
            begin
                bias  = bblur_pkg::BIAS_INNER;
                recip = bblur_pkg::RECIP_INNER;
            end
            default:
            begin
                bias  = bblur_pkg::BIAS_INNER;
                recip = bblur_pkg::RECIP_INNER;
            end
        endcase
    end

    always_comb
    begin
        for (int ch = 0; ch < 3; ch++)
        begin
            prod[ch] = PROD_W'(s3_num_reg[ch]) * PROD_W'(s3_recip_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s1_valid_reg  <= q_valid;
            s2_valid_reg  <= s1_valid_reg && s1_ctl_reg.emit;
            s3_valid_reg  <= s2_valid_reg;
            out_valid_reg <= s3_valid_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign red_out   = chan_out_reg[0];
    assign green_out = chan_out_reg[1];
    assign blue_out  = chan_out_reg[2];
    assign frame_end = frame_end_reg;

endmodule

@@ design/box_blur_3x3_border_aware.sv @@
`timescale 1ns / 1ps
// top level of the streaming 3x3 border-aware box blur over rgb pixels
// depends on bblur_pkg, bblur_front, bblur_queue and bblur_back
//
//  channel  direction  handshake            payload
//  cfg      in         cfg_valid/cfg_ready  cfg_index, cfg_data
//  in       in         in_valid/in_stall    opcode, red_in, green_in, blue_in
//  out      out        out_valid/out_stall  red_out, green_out, blue_out, frame_end
//
// one item per cycle while out_stall is low, set by the single-port-pair line buffer ram
// the item completing a result passes the queue, s1, window, s3 and output registers
// reset: 640x480 frame, positions at zero, line buffers left uninitialized
// out_stall freezes the blur pipeline; the four-entry queue keeps taking input until full
module box_blur_3x3_border_aware #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [bblur_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [bblur_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic                             opcode,
    input  logic [bblur_pkg::CH_W-1:0]       red_in,
    input  logic [bblur_pkg::CH_W-1:0]       green_in,
    input  logic [bblur_pkg::CH_W-1:0]       blue_in,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic [bblur_pkg::CH_W-1:0]       red_out,
    output logic [bblur_pkg::CH_W-1:0]       green_out,
    output logic [bblur_pkg::CH_W-1:0]       blue_out,
    output logic                             frame_end
);

    localparam int COL_W  = $clog2(MAX_WIDTH);
    localparam int CTL_W  = $bits(bblur_pkg::ctl_t);
    localparam int PIX_W  = bblur_pkg::PIX_W;
    localparam int ITEM_W = PIX_W + COL_W + CTL_W;

    logic              in_acc;
    logic              q_push;
    logic [PIX_W-1:0]  f_pix;
    logic [COL_W-1:0]  f_col;
    bblur_pkg::ctl_t   f_ctl;
    logic              q_full;
    logic              q_not_empty;
    logic              q_pop;
    logic [ITEM_W-1:0] q_head;

    assign cfg_ready = 1'b1;
    assign in_stall  = q_full;
    assign in_acc    = in_valid && !in_stall;

    bblur_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr    (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_acc    (in_acc),
        .opcode    (opcode),
        .red_in    (red_in),
        .green_in  (green_in),
        .blue_in   (blue_in),
        .q_push    (q_push),
        .q_pix     (f_pix),
        .q_col     (f_col),
        .q_ctl     (f_ctl)
    );

    bblur_queue #(
        .WIDTH (ITEM_W),
        .DEPTH (bblur_pkg::QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data ({f_pix, f_col, f_ctl}),
        .pop       (q_pop),
        .full      (q_full),
        .not_empty (q_not_empty),
        .head      (q_head)
    );

    bblur_back #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_not_empty),
        .q_pix     (q_head[ITEM_W-1 -: PIX_W]),
        .q_col     (q_head[CTL_W +: COL_W]),
        .q_ctl     (bblur_pkg::ctl_t'(q_head[CTL_W-1:0])),
        .q_pop     (q_pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .red_out   (red_out),
        .green_out (green_out),
        .blue_out  (blue_out),
        .frame_end (frame_end)
    );

endmodule
